>>> hdl/ttsr_pkg.sv
// ----------------------------------------------------------------------------
// ttsr_pkg
// Shared types, constants and bit helpers for the support reducer.
// ----------------------------------------------------------------------------
package ttsr_pkg;

    localparam int C_WORD_W      = 64;
    localparam int C_IDX_W       = 6;
    localparam int C_CNT_W       = 3;
    localparam int C_PAIR_W      = C_IDX_W - 1;
    localparam int MAX_VARS_DEF  = 6;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    typedef struct packed {
        logic                 wr_en;
        logic [C_IDX_W-1:0]   wr_addr;
        logic                 clr_mask;
        logic                 pair_en;
        logic [C_IDX_W-1:0]   pair_lo;
        logic [C_IDX_W-1:0]   pair_hi;
        logic [C_CNT_W-1:0]   pair_var;
        logic                 emit_rd;
        logic [C_IDX_W-1:0]   emit_idx;
        logic                 out_load;
        logic                 out_last;
    } t_cmd;

    typedef struct packed {
        logic [C_CNT_W-1:0]   live_count;
        logic                 out_free;
    } t_stat;

    // insert a zero at bit position v of k
    function automatic logic [C_IDX_W-1:0] f_pair_lo(
        input logic [C_PAIR_W-1:0] k,
        input logic [C_CNT_W-1:0]  v
    );
        logic [C_IDX_W-1:0] kx;
        logic [C_IDX_W-1:0] lo_mask;
        kx      = {1'b0, k};
        lo_mask = C_IDX_W'((7'd1 << v) - 7'd1);
        return ((kx & ~lo_mask) << 1) | (kx & lo_mask);
    endfunction

    // parallel deposit of j into the set bits of mask
    function automatic logic [C_IDX_W-1:0] f_deposit(
        input logic [C_IDX_W-1:0] j,
        input logic [C_IDX_W-1:0] mask
    );
        logic [C_IDX_W-1:0] res;
        logic [C_CNT_W-1:0] src;
        res = '0;
        src = '0;
        for (int b = 0; b < C_IDX_W; b++) begin
            if (mask[b]) begin
                res[b] = j[src];
                src    = src + 3'd1;
            end
        end
        return res;
    endfunction

    function automatic logic [C_CNT_W-1:0] f_popcount(input logic [C_IDX_W-1:0] m);
        logic [C_CNT_W-1:0] c;
        c = '0;
        for (int b = 0; b < C_IDX_W; b++) begin
            c = c + C_CNT_W'(m[b]);
        end
        return c;
    endfunction

endpackage

>>> hdl/ttsr_ctrl.sv
// ----------------------------------------------------------------------------
// ttsr_ctrl
// Sequencer: table load, pairwise variable scan and compacted readout.
// ----------------------------------------------------------------------------
module ttsr_ctrl #(
    parameter int MAX_VARS = ttsr_pkg::MAX_VARS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_cfg_we,
    input  logic [ttsr_pkg::C_CNT_W-1:0] i_cfg_data,
    input  ttsr_pkg::t_stat             i_stat,
    output ttsr_pkg::t_cmd              o_cmd,
    output logic                        o_stall
);
    import ttsr_pkg::*;

    t_state               r_state, n_state;
    logic [C_CNT_W-1:0]   r_num_vars, n_num_vars;
    logic [C_IDX_W-1:0]   r_load_cnt, n_load_cnt;
    logic [C_CNT_W-1:0]   r_var, n_var;
    logic [C_PAIR_W-1:0]  r_pair, n_pair;
    logic [C_IDX_W-1:0]   r_emit_idx, n_emit_idx;

    logic [C_IDX_W-1:0]   len_m1;
    logic [C_PAIR_W-1:0]  half_m1;
    logic [C_IDX_W-1:0]   red_m1;
    logic                 in_acc;
    logic                 load_last;
    logic                 pair_last;
    logic                 var_last;
    logic                 emit_last;

    assign len_m1    = C_IDX_W'((7'd1 << r_num_vars) - 7'd1);
    assign half_m1   = C_PAIR_W'(len_m1 >> 1);
    assign red_m1    = C_IDX_W'((7'd1 << i_stat.live_count) - 7'd1);
    assign in_acc    = i_valid && (r_state == S_LOAD);
    assign load_last = (r_load_cnt == len_m1);
    assign pair_last = (r_pair == half_m1);
    assign var_last  = (r_var == r_num_vars - 3'd1);
    assign emit_last = (r_emit_idx == red_m1);
    assign o_stall   = (r_state != S_LOAD);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (in_acc && load_last) begin
                    n_state = (r_num_vars == '0) ? S_EMIT_RD : S_SCAN;
                end
            end
            S_SCAN: begin
                if (pair_last && var_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:   n_state = S_EMIT_RD;
            S_EMIT_RD: begin
                if (i_stat.out_free) begin
                    n_state = S_EMIT_LD;
                end
            end
            S_EMIT_LD: n_state = emit_last ? S_LOAD : S_EMIT_RD;
            default:   n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.wr_addr  = r_load_cnt;
        o_cmd.pair_lo  = f_pair_lo(r_pair, r_var);
        o_cmd.pair_hi  = f_pair_lo(r_pair, r_var) | C_IDX_W'(7'd1 << r_var);
        o_cmd.pair_var = r_var;
        o_cmd.emit_idx = r_emit_idx;
        o_cmd.out_last = emit_last;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.wr_en    = in_acc;
                o_cmd.clr_mask = in_acc && load_last;
            end
            S_SCAN:    o_cmd.pair_en  = 1'b1;
            S_DRAIN:   o_cmd.pair_en  = 1'b0;
            S_EMIT_RD: o_cmd.emit_rd  = i_stat.out_free;
            S_EMIT_LD: o_cmd.out_load = 1'b1;
            default:   o_cmd          = '0;
        endcase
    end

    always_comb begin
        n_num_vars = r_num_vars;
        n_load_cnt = r_load_cnt;
        n_var      = r_var;
        n_pair     = r_pair;
        n_emit_idx = r_emit_idx;
        if (i_cfg_we) begin
            n_num_vars = (i_cfg_data > C_CNT_W'(MAX_VARS)) ? C_CNT_W'(MAX_VARS) : i_cfg_data;
            n_load_cnt = '0;
        end else if (in_acc) begin
            n_load_cnt = load_last ? '0 : r_load_cnt + 6'd1;
            n_var      = '0;
            n_pair     = '0;
            n_emit_idx = '0;
        end
        if (r_state == S_SCAN) begin
            n_pair = pair_last ? '0 : r_pair + 5'd1;
            if (pair_last) begin
                n_var = r_var + 3'd1;
            end
        end
        if (r_state == S_EMIT_LD) begin
            n_emit_idx = r_emit_idx + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_num_vars <= '0;
            r_load_cnt <= '0;
            r_var      <= '0;
            r_pair     <= '0;
            r_emit_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_num_vars <= n_num_vars;
            r_load_cnt <= n_load_cnt;
            r_var      <= n_var;
            r_pair     <= n_pair;
            r_emit_idx <= n_emit_idx;
        end
    end

endmodule

>>> hdl/ttsr_dp.sv
// ----------------------------------------------------------------------------
// ttsr_dp
// Table memory, pair compare into the live mask, and output register.
// ----------------------------------------------------------------------------
module ttsr_dp #(
    parameter int MAX_VARS = ttsr_pkg::MAX_VARS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ttsr_pkg::t_cmd                i_cmd,
    input  logic [ttsr_pkg::C_WORD_W-1:0] i_entry_value,
    input  logic                          i_stall,
    output ttsr_pkg::t_stat               o_stat,
    output logic                          o_valid,
    output logic [ttsr_pkg::C_IDX_W-1:0]  o_reduced_index,
    output logic [ttsr_pkg::C_WORD_W-1:0] o_reduced_value,
    output logic [ttsr_pkg::C_IDX_W-1:0]  o_live_mask,
    output logic [ttsr_pkg::C_CNT_W-1:0]  o_live_count,
    output logic                          o_last_result
);
    import ttsr_pkg::*;

    localparam int DEPTH = 1 << MAX_VARS;

    logic [C_WORD_W-1:0] mem [DEPTH];
    logic [C_WORD_W-1:0] r_rd_a;
    logic [C_WORD_W-1:0] r_rd_b;
    logic                r_cmp_valid;
    logic [C_CNT_W-1:0]  r_cmp_var;
    logic [C_IDX_W-1:0]  r_mask;
    logic                r_out_valid;
    logic [C_IDX_W-1:0]  rd_a_addr;
    logic [C_CNT_W-1:0]  live_count;

    assign rd_a_addr  = i_cmd.emit_rd ? f_deposit(i_cmd.emit_idx, r_mask) : i_cmd.pair_lo;
    assign live_count = f_popcount(r_mask);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_cmd.wr_addr[MAX_VARS-1:0]] <= i_entry_value;
        end
        r_rd_a <= mem[rd_a_addr[MAX_VARS-1:0]];
        r_rd_b <= mem[i_cmd.pair_hi[MAX_VARS-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_valid <= i_cmd.pair_en;
            if (i_cmd.clr_mask) begin
                r_mask <= '0;
            end else if (r_cmp_valid && (r_rd_a != r_rd_b)) begin
                r_mask[r_cmp_var] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_var <= i_cmd.pair_var;
        if (i_cmd.out_load) begin
            o_reduced_index <= i_cmd.emit_idx;
            o_reduced_value <= r_rd_a;
            o_live_mask     <= r_mask;
            o_live_count    <= live_count;
            o_last_result   <= i_cmd.out_last;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_stat.live_count = live_count;
    assign o_stat.out_free   = !r_out_valid || !i_stall;

endmodule

>>> hdl/truth_table_support_reducer.sv
// ----------------------------------------------------------------------------
// truth_table_support_reducer
// Loads 2^n signature words, finds live variables, emits the compacted table.
// ----------------------------------------------------------------------------
// Load: one word per cycle while o_stall is low. Scan: one word pair
// compared per cycle through the two memory read ports. Readout: each
// result is a memory read, then an output register load, held while stalled.
// Synchronous active-low reset clears control state and r_num_vars to zero;
// the table memory is not cleared and is only read after it is loaded.
module truth_table_support_reducer #(
    parameter int MAX_VARS = ttsr_pkg::MAX_VARS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ttsr_pkg::C_CNT_W-1:0]  i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ttsr_pkg::C_WORD_W-1:0] i_entry_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ttsr_pkg::C_IDX_W-1:0]  o_reduced_index,
    output logic [ttsr_pkg::C_WORD_W-1:0] o_reduced_value,
    output logic [ttsr_pkg::C_IDX_W-1:0]  o_live_mask,
    output logic [ttsr_pkg::C_CNT_W-1:0]  o_live_count,
    output logic                          o_last_result
);
    import ttsr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ttsr_ctrl #(.MAX_VARS(MAX_VARS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_stall    (o_stall)
    );

    ttsr_dp #(.MAX_VARS(MAX_VARS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_entry_value   (i_entry_value),
        .i_stall         (i_stall),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_reduced_index (o_reduced_index),
        .o_reduced_value (o_reduced_value),
        .o_live_mask     (o_live_mask),
        .o_live_count    (o_live_count),
        .o_last_result   (o_last_result)
    );

endmodule

>>> hdl/ttsr_chk.sv
// ----------------------------------------------------------------------------
// ttsr_chk
// Port-level checks on the support reducer result channel.
// ----------------------------------------------------------------------------
module ttsr_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [ttsr_pkg::C_IDX_W-1:0]  o_reduced_index,
    input logic [ttsr_pkg::C_WORD_W-1:0] o_reduced_value,
    input logic [ttsr_pkg::C_IDX_W-1:0]  o_live_mask,
    input logic [ttsr_pkg::C_CNT_W-1:0]  o_live_count,
    input logic                          o_last_result
);
    import ttsr_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_reduced_value)
            && $stable(o_reduced_index) && $stable(o_last_result))
        else $error("result changed while stalled");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones(o_live_mask) == int'(o_live_count)))
        else $error("live count does not match live mask");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_result |->
            (o_reduced_index == C_IDX_W'((7'd1 << o_live_count) - 7'd1)))
        else $error("last result not at final compacted index");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_reduced_index >> o_live_count) == '0))
        else $error("compacted index out of range");

endmodule

bind truth_table_support_reducer ttsr_chk u_ttsr_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_reduced_index (o_reduced_index),
    .o_reduced_value (o_reduced_value),
    .o_live_mask     (o_live_mask),
    .o_live_count    (o_live_count),
    .o_last_result   (o_last_result)
);
